@@ sv/dda_line_point_generator_defines.svh @@
// Assertion macros for the DDA line point generator RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef DDA_LINE_POINT_GENERATOR_DEFINES_SVH
`define DDA_LINE_POINT_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DDA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

@@ sv/dda_pkg.sv @@
// Shared constants and controller/datapath interface types for the DDA line generator.
// Depends on nothing.
`default_nettype none

package dda_pkg;

	// Fixed field widths of the block.
	localparam int COORD_W = 6;
	localparam int POINT_W = 22;

	// Defaults for the top-level parameters.
	localparam int TILE_SIZE_DEF = 64;
	localparam int FRAC_BITS_DEF = 16;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture a new line and set up the divisions
		logic div_step;  // one restoring division step on both axes
		logic advance;   // point transaction done, move to the next point
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic steps_zero; // zero-length line, no division needed
		logic div_last;   // current division step is the final one
		logic last;       // current point is the final point of the line
	} dp_status_t;

endpackage

`default_nettype wire

@@ sv/dda_line_point_generator.sv @@
// DDA line point generator.
// Input channel: one line per transaction, given as start_x/start_y and end_x/end_y
// pixel coordinates inside the tile; coordinates past the tile edge are saturated.
// Output channel: steps+1 point transactions per line, steps = max(|dx|, |dy|),
// each with point_x/point_y in unsigned Q6.16 and last_point high on the final one.
// Timing: the line is loaded in its accept cycle, then bit-serial division (both axes
// in parallel) runs before the first point is offered; a zero-length line skips the
// division steps. Then one point leaves per cycle while the receiver is ready.
// Throughput is one line at a time: in_ready is high only while the block is idle.
// A stalled receiver holds the current point and everything behind it.
// Reset (arst_n low) returns the block to idle, ready for a line; no clearing pass.
// Depends on dda_pkg, dda_ctrl and dda_datapath.
`default_nettype none

module dda_line_point_generator #(
	parameter int TILE_SIZE = dda_pkg::TILE_SIZE_DEF,
	parameter int FRAC_BITS = dda_pkg::FRAC_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [dda_pkg::COORD_W-1:0]  start_x,
	input  wire logic [dda_pkg::COORD_W-1:0]  start_y,
	input  wire logic [dda_pkg::COORD_W-1:0]  end_x,
	input  wire logic [dda_pkg::COORD_W-1:0]  end_y,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [dda_pkg::POINT_W-1:0]       point_x,
	output logic [dda_pkg::POINT_W-1:0]       point_y,
	output logic                              last_point
);
	import dda_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// Sequencing and handshakes.
	dda_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Division and point arithmetic.
	dda_datapath #(
		.TILE_SIZE (TILE_SIZE),
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.clk     (clk),
		.cmd     (cmd),
		.start_x (start_x),
		.start_y (start_y),
		.end_x   (end_x),
		.end_y   (end_y),
		.status  (status),
		.point_x (point_x),
		.point_y (point_y)
	);

	assign last_point = status.last;

endmodule

`default_nettype wire

@@ sv/dda_datapath.sv @@
// Datapath of the DDA line generator: endpoint capture, two bit-serial dividers
// and the x/y point accumulators. Depends on dda_pkg.
`default_nettype none

module dda_datapath #(
	parameter int TILE_SIZE = dda_pkg::TILE_SIZE_DEF,
	parameter int FRAC_BITS = dda_pkg::FRAC_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire dda_pkg::dp_cmd_t               cmd,
	input  wire logic [dda_pkg::COORD_W-1:0]    start_x,
	input  wire logic [dda_pkg::COORD_W-1:0]    start_y,
	input  wire logic [dda_pkg::COORD_W-1:0]    end_x,
	input  wire logic [dda_pkg::COORD_W-1:0]    end_y,
	output dda_pkg::dp_status_t                 status,
	output logic [dda_pkg::POINT_W-1:0]         point_x,
	output logic [dda_pkg::POINT_W-1:0]         point_y
);
	import dda_pkg::*;

	// Dividend/quotient width, step counter width and accumulator width.
	localparam int DIV_N = COORD_W + FRAC_BITS;
	localparam int CNT_W = $clog2(DIV_N);
	localparam int ACC_W = (FRAC_BITS + 8 > POINT_W) ? FRAC_BITS + 8 : POINT_W;
	localparam logic [COORD_W-1:0] TILE_MAX = COORD_W'(TILE_SIZE - 1);

	logic [COORD_W-1:0] cx0, cy0, cx1, cy1;
	logic [COORD_W-1:0] adx, ady, steps;

	logic [COORD_W-1:0] steps_q;
	logic               neg_x_q, neg_y_q;
	logic [DIV_N-1:0]   dvd_x_q, dvd_y_q;
	logic [COORD_W-1:0] rem_x_q, rem_y_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [COORD_W-1:0] k_q;
	logic [ACC_W-1:0]   acc_x_q, acc_y_q;

	logic [COORD_W:0]   rsh_x, rsh_y;
	logic               ge_x, ge_y;
	logic [COORD_W-1:0] rem_x_d, rem_y_d;
	logic [ACC_W-1:0]   inc_x, inc_y;

	// Saturate the endpoints to the tile and find the step count.
	always_comb begin
		cx0   = (start_x > TILE_MAX) ? TILE_MAX : start_x;
		cy0   = (start_y > TILE_MAX) ? TILE_MAX : start_y;
		cx1   = (end_x > TILE_MAX) ? TILE_MAX : end_x;
		cy1   = (end_y > TILE_MAX) ? TILE_MAX : end_y;
		adx   = (cx1 >= cx0) ? cx1 - cx0 : cx0 - cx1;
		ady   = (cy1 >= cy0) ? cy1 - cy0 : cy0 - cy1;
		steps = (adx > ady) ? adx : ady;
	end

	// One restoring division step per axis; the dividend register collects the quotient.
	always_comb begin
		rsh_x   = {rem_x_q, dvd_x_q[DIV_N-1]};
		rsh_y   = {rem_y_q, dvd_y_q[DIV_N-1]};
		ge_x    = rsh_x >= {1'b0, steps_q};
		ge_y    = rsh_y >= {1'b0, steps_q};
		rem_x_d = ge_x ? COORD_W'(rsh_x - {1'b0, steps_q}) : rsh_x[COORD_W-1:0];
		rem_y_d = ge_y ? COORD_W'(rsh_y - {1'b0, steps_q}) : rsh_y[COORD_W-1:0];
	end

	// The increment magnitude never exceeds one pixel, so FRAC_BITS+1 bits hold it.
	assign inc_x = ACC_W'(dvd_x_q[FRAC_BITS:0]);
	assign inc_y = ACC_W'(dvd_y_q[FRAC_BITS:0]);

	// Line setup, division and point stepping.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			steps_q <= steps;
			neg_x_q <= cx1 < cx0;
			neg_y_q <= cy1 < cy0;
			dvd_x_q <= {adx, {FRAC_BITS{1'b0}}};
			dvd_y_q <= {ady, {FRAC_BITS{1'b0}}};
			rem_x_q <= '0;
			rem_y_q <= '0;
			cnt_q   <= '0;
			k_q     <= '0;
			acc_x_q <= ACC_W'({cx0, {FRAC_BITS{1'b0}}});
			acc_y_q <= ACC_W'({cy0, {FRAC_BITS{1'b0}}});
		end else if (cmd.div_step) begin
			dvd_x_q <= {dvd_x_q[DIV_N-2:0], ge_x};
			dvd_y_q <= {dvd_y_q[DIV_N-2:0], ge_y};
			rem_x_q <= rem_x_d;
			rem_y_q <= rem_y_d;
			cnt_q   <= cnt_q + 1'b1;
		end else if (cmd.advance) begin
			k_q     <= k_q + 1'b1;
			acc_x_q <= neg_x_q ? acc_x_q - inc_x : acc_x_q + inc_x;
			acc_y_q <= neg_y_q ? acc_y_q - inc_y : acc_y_q + inc_y;
		end
	end

	// Status toward the controller and the point outputs.
	always_comb begin
		status.steps_zero = steps_q == '0;
		status.div_last   = cnt_q == CNT_W'(DIV_N - 1);
		status.last       = k_q == steps_q;
	end

	assign point_x = acc_x_q[POINT_W-1:0];
	assign point_y = acc_y_q[POINT_W-1:0];

endmodule

`default_nettype wire

@@ sv/dda_ctrl.sv @@
// Controller state machine of the DDA line generator: input and output handshakes
// and sequencing of setup, division and point stepping. Depends on dda_pkg.
`default_nettype none
`include "dda_line_point_generator_defines.svh"

module dda_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	input  wire dda_pkg::dp_status_t  status,
	output dda_pkg::dp_cmd_t          cmd
);
	import dda_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0] state_q, state_d;

	// Next state and datapath commands.
	always_comb begin
		state_d      = state_q;
		cmd.load     = 1'b0;
		cmd.div_step = 1'b0;
		cmd.advance  = 1'b0;
		in_ready     = 1'b0;
		out_valid    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				if (status.steps_zero) begin
					state_d = ST_EMIT;
				end else begin
					cmd.div_step = 1'b1;
					if (status.div_last) begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.advance = 1'b1;
					if (status.last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// A new line is never taken while a point is on offer.
	`DDA_ASSERT_IMPLY(a_no_overlap, clk, arst_n, out_valid, !in_ready)
	// An accepted line always goes through setup before its first point.
	`DDA_ASSERT_NEXT(a_load_then_busy, clk, arst_n, in_valid && in_ready, !in_ready && !out_valid)
	// The final point transaction returns the block to idle.
	`DDA_ASSERT_NEXT(a_last_to_idle, clk, arst_n, out_valid && out_ready && status.last, in_ready)

endmodule

`default_nettype wire

@@ test/dda_line_point_generator_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for dda_line_point_generator: drives lines and checks each point.
// Depends on dda_pkg and the dda_line_point_generator RTL.

module dda_line_point_generator_tb;

	import dda_pkg::*;

	localparam int TILE = TILE_SIZE_DEF;
	localparam int FRAC = FRAC_BITS_DEF;
	localparam int LONG_HOLD = 250;

	typedef struct {
		logic [COORD_W-1:0] sx;
		logic [COORD_W-1:0] sy;
		logic [COORD_W-1:0] ex;
		logic [COORD_W-1:0] ey;
	} line_t;

	typedef struct {
		logic [POINT_W-1:0] x;
		logic [POINT_W-1:0] y;
		logic               last;
	} point_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [COORD_W-1:0] start_x = '0;
	logic [COORD_W-1:0] start_y = '0;
	logic [COORD_W-1:0] end_x = '0;
	logic [COORD_W-1:0] end_y = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [POINT_W-1:0] point_x;
	logic [POINT_W-1:0] point_y;
	logic               last_point;

	line_t  line_q[$];
	point_t point_q[$];
	line_t  next_line;
	point_t want;
	logic   in_took = 1'b0;
	logic   idle_on = 1'b1;
	logic   long_hold_done = 1'b0;
	int     send_gap = 0;
	int     stall_left = 0;
	int     lines_total = 0;
	int     lines_taken = 0;
	int     points_seen = 0;
	int     mismatch_count = 0;

	dda_line_point_generator #(
		.TILE_SIZE(TILE),
		.FRAC_BITS(FRAC)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.start_x(start_x),
		.start_y(start_y),
		.end_x(end_x),
		.end_y(end_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.point_x(point_x),
		.point_y(point_y),
		.last_point(last_point)
	);

	// Free-running clock, 2 ns period.
	always #1 clk = ~clk;

	// Coordinates past the tile edge are saturated to the last pixel.
	function automatic longint unsigned clip_coord(input logic [COORD_W-1:0] c);
		longint unsigned v;
		v = c;
		if (v > TILE - 1) begin
			v = TILE - 1;
		end
		return v;
	endfunction

	// Signed per-step increment in fixed point, truncated toward zero.
	function automatic longint unsigned axis_step(input longint unsigned a0,
			input longint unsigned a1, input longint unsigned steps);
		longint unsigned mag;
		longint unsigned q;
		if (steps == 0) begin
			return 0;
		end
		mag = (a1 < a0) ? a0 - a1 : a1 - a0;
		q = (mag << FRAC) / steps;
		return (a1 < a0) ? 64'd0 - q : q;
	endfunction

	// Walks one line and queues every point that it must produce.
	task automatic add_line_points(input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
			input logic [COORD_W-1:0] ex, input logic [COORD_W-1:0] ey);
		longint unsigned x0, y0, x1, y1, adx, ady, steps, xinc, yinc, xacc, yacc, k;
		point_t pt;
		x0 = clip_coord(sx);
		y0 = clip_coord(sy);
		x1 = clip_coord(ex);
		y1 = clip_coord(ey);
		adx = (x1 >= x0) ? x1 - x0 : x0 - x1;
		ady = (y1 >= y0) ? y1 - y0 : y0 - y1;
		steps = (adx > ady) ? adx : ady;
		xinc = axis_step(x0, x1, steps);
		yinc = axis_step(y0, y1, steps);
		xacc = x0 << FRAC;
		yacc = y0 << FRAC;
		for (k = 0; k <= steps; k++) begin
			pt.x = xacc[POINT_W-1:0];
			pt.y = yacc[POINT_W-1:0];
			pt.last = (k == steps);
			point_q = {point_q, pt};
			xacc += xinc;
			yacc += yinc;
		end
	endtask

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		mismatch_count++;
	endtask

	task automatic queue_line(input int sx, input int sy, input int ex, input int ey);
		line_t ln;
		ln.sx = sx[COORD_W-1:0];
		ln.sy = sy[COORD_W-1:0];
		ln.ex = ex[COORD_W-1:0];
		ln.ey = ey[COORD_W-1:0];
		line_q = {line_q, ln};
		lines_total++;
	endtask

	function automatic int near_coord(input int c);
		int v;
		v = c + $urandom_range(0, 6) - 3;
		if (v < 0) begin
			v = 0;
		end
		if (v > TILE - 1) begin
			v = TILE - 1;
		end
		return v;
	endfunction

	// Input driver: offers the next queued line and holds it until the transaction completes.
	always @(negedge clk) begin
		if (arst_n && !(in_valid && !in_took)) begin
			if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap--;
			end else if (line_q.size() > 0) begin
				next_line = line_q.pop_front();
				start_x <= next_line.sx;
				start_y <= next_line.sy;
				end_x <= next_line.ex;
				end_y <= next_line.ey;
				in_valid <= 1'b1;
				if (idle_on && $urandom_range(0, 3) == 0) begin
					send_gap = $urandom_range(1, 12);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver ready: random stall bursts, plus one long hold-off to back the block up.
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (!long_hold_done && points_seen >= 300) begin
				long_hold_done = 1'b1;
				stall_left = LONG_HOLD - 1;
				out_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 11);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Monitor: predicts points for each accepted line and checks each point transaction.
	always @(posedge clk) begin
		in_took <= in_valid && in_ready;
		if (in_valid && in_ready) begin
			add_line_points(start_x, start_y, end_x, end_y);
			lines_taken++;
		end
		if (out_valid && out_ready) begin
			points_seen++;
			if (point_q.size() == 0) begin
				report_mismatch($sformatf("unexpected point x=%h y=%h last=%b",
					point_x, point_y, last_point));
			end else begin
				want = point_q.pop_front();
				if (point_x !== want.x) begin
					report_mismatch($sformatf("point_x got %h want %h", point_x, want.x));
				end
				if (point_y !== want.y) begin
					report_mismatch($sformatf("point_y got %h want %h", point_y, want.y));
				end
				if (last_point !== want.last) begin
					report_mismatch($sformatf("last_point got %b want %b",
						last_point, want.last));
				end
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		int kind, sx, sy, ex, ey;

		// Directed lines: zero length, tile corners, diagonals, axis-aligned, several octants, steps of one.
		queue_line(0, 0, 0, 0);
		queue_line(63, 63, 63, 63);
		queue_line(0, 0, 63, 63);
		queue_line(63, 63, 0, 0);
		queue_line(0, 63, 63, 0);
		queue_line(63, 0, 0, 63);
		queue_line(0, 0, 63, 0);
		queue_line(63, 0, 0, 0);
		queue_line(0, 0, 0, 63);
		queue_line(0, 63, 0, 0);
		queue_line(10, 10, 11, 10);
		queue_line(10, 10, 10, 9);
		queue_line(20, 20, 21, 21);
		queue_line(0, 0, 63, 1);
		queue_line(0, 0, 1, 63);
		queue_line(63, 1, 0, 0);
		queue_line(5, 7, 12, 40);
		queue_line(40, 12, 7, 5);
		queue_line(30, 30, 33, 1);
		queue_line(0, 21, 63, 42);
		queue_line(42, 0, 21, 63);
		queue_line(31, 32, 32, 31);

		// Random lines: mostly full-range, with short, axis-aligned, degenerate and corner-to-corner mixes.
		repeat (388) begin
			kind = $urandom_range(0, 9);
			sx = $urandom_range(0, TILE - 1);
			sy = $urandom_range(0, TILE - 1);
			ex = $urandom_range(0, TILE - 1);
			ey = $urandom_range(0, TILE - 1);
			if (kind == 6 || kind == 7) begin
				ex = near_coord(sx);
				ey = near_coord(sy);
			end else if (kind == 8) begin
				if ($urandom_range(0, 1) == 1) begin
					ey = sy;
				end else begin
					ex = sx;
				end
			end else if (kind == 9) begin
				if ($urandom_range(0, 1) == 1) begin
					ex = sx;
					ey = sy;
				end else begin
					sx = $urandom_range(0, 1) * (TILE - 1);
					sy = $urandom_range(0, 1) * (TILE - 1);
					ex = (TILE - 1) - sx;
					ey = (TILE - 1) - sy;
				end
			end
			queue_line(sx, sy, ex, ey);
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// A quiet stretch in the middle, and no idling at all near the end.
		while (line_q.size() > 250) @(posedge clk);
		idle_on = 1'b0;
		while (line_q.size() > 200) @(posedge clk);
		idle_on = 1'b1;
		while (line_q.size() > 60) @(posedge clk);
		idle_on = 1'b0;

		while (lines_taken < lines_total) @(posedge clk);
		while (point_q.size() > 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#3_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
